/* rtl/core/lhlf_pkg.sv */
// Shared types, codes and helpers of the letter histogram block.
// Depends on nothing; every other file of the block but lhlf_if uses it.
`default_nettype none

package lhlf_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_LETTERS  = 26;
    localparam int LETTER_IDX_W = 5;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [LETTER_IDX_W-1:0] letter_idx_t;

    localparam count_t      COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam letter_idx_t LAST_LETTER = LETTER_IDX_W'(NUM_LETTERS - 1);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [1:0] OP_COLLECT = 2'd0;
    localparam logic [1:0] OP_RATIO   = 2'd1;
    localparam logic [1:0] OP_SINGLE  = 2'd2;
    localparam logic [1:0] OP_REPORT  = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EMPTY      = 2'd1,
        STATUS_NOT_LETTER = 2'd2,
        STATUS_NO_LETTERS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MINSCAN,
        ST_EMIT_UP,
        ST_EMIT_LO,
        ST_FLUSH
    } state_t;

    // Contents of one cell: a case-folded counter and the two case flags.
    typedef struct packed {
        count_t count;
        logic   up;
        logic   lo;
    } cell_data_t;

    typedef struct packed {
        logic shift;
        logic inc;
        logic mark_up;
        logic mark_lo;
    } cell_ctrl_t;

    typedef struct packed {
        status_t       status;
        logic [7:0]    letter_code;
        logic [15:0]   hit_count;
        logic [15:0]   total_count;
        logic          last;
    } result_t;

    typedef struct packed {
        logic        is_letter;
        logic        is_lower;
        letter_idx_t idx;
    } letter_info_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic letter_info_t decode_letter(input logic [7:0] ch);
        letter_info_t r;
        r = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            r.is_letter = 1'b1;
            r.idx       = LETTER_IDX_W'(ch - CHAR_UPPER_A);
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            r.is_letter = 1'b1;
            r.is_lower  = 1'b1;
            r.idx       = LETTER_IDX_W'(ch - CHAR_LOWER_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lhlf_if.sv */
// Valid/ready channel interfaces for the command and result streams.
// Depends on nothing.
`default_nettype none

interface lhlf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

interface lhlf_rsp_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [7:0]           letter_code;
    logic [15:0]          hit_count;
    logic [15:0]          total_count;
    logic                 last;

    modport source (output valid, output status, output letter_code, output hit_count,
                    output total_count, output last, input ready);
    modport sink   (input valid, input status, input letter_code, input hit_count,
                    input total_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/letter_histogram_least_frequent.sv */
// Top level of the letter histogram: totals, the 26-cell letter ring and the
// query sequencer with its output register. Depends on lhlf_pkg, lhlf_if, lhlf_cell.
//
//   port  direction  carries
//   cmd   in         operation, character
//   rsp   out        status, letter_code, hit_count, total_count, last
//
// A collect, ratio or single-letter transaction completes in the idle state.
// A report on a non-empty store rotates the ring of 26 cells through the head
// comparator one place a cycle, unless a stalled rsp holds an emit: a minimum scan,
// upper- then lower-case emit, a flush of the final result; cmd is not ready meanwhile.
// Queries wait for a free output register; collects do not.
// Reset clears all counters and flags at once.
`default_nettype none

module letter_histogram_least_frequent (
    input wire logic  clk,
    input wire logic  rst_n,
    lhlf_cmd_if.sink  cmd,
    lhlf_rsp_if.source rsp
);

    lhlf_pkg::cell_data_t cell_q    [lhlf_pkg::NUM_LETTERS];
    lhlf_pkg::cell_ctrl_t cell_ctrl [lhlf_pkg::NUM_LETTERS];

    lhlf_pkg::state_t      state_reg, state_next;
    lhlf_pkg::letter_idx_t step_reg, step_next;
    lhlf_pkg::count_t      chars_reg, chars_next;
    lhlf_pkg::count_t      letters_reg, letters_next;
    lhlf_pkg::count_t      min_reg, min_next;
    logic                  any_reg, any_next;
    logic                  pend_valid_reg, pend_valid_next;
    lhlf_pkg::result_t     pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    lhlf_pkg::result_t     out_reg, out_next;

    lhlf_pkg::letter_info_t info;
    lhlf_pkg::cell_data_t   head;
    logic                   out_free;
    logic                   accept;
    logic                   shift;
    logic                   col_inc;

    // Ring: each cell takes its upper neighbor, so cell 0 sees letters in order.
    for (genvar i = 0; i < lhlf_pkg::NUM_LETTERS; i++)
    begin : g_cell
        lhlf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[i]),
            .neighbor (cell_q[(i + 1) % lhlf_pkg::NUM_LETTERS]),
            .data     (cell_q[i])
        );
    end

    assign info     = lhlf_pkg::decode_letter(cmd.character);
    assign head     = cell_q[0];
    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == lhlf_pkg::ST_IDLE) &&
                       (cmd.operation == lhlf_pkg::OP_COLLECT || out_free);
    assign accept   = cmd.valid && cmd.ready;

    always_comb
    begin
        for (int i = 0; i < lhlf_pkg::NUM_LETTERS; i++)
        begin
            cell_ctrl[i].shift   = shift;
            cell_ctrl[i].inc     = col_inc && (info.idx == lhlf_pkg::LETTER_IDX_W'(i));
            cell_ctrl[i].mark_up = !info.is_lower;
            cell_ctrl[i].mark_lo = info.is_lower;
        end
    end

    always_comb
    begin
        logic match;
        logic flag;
        state_next      = state_reg;
        step_next       = step_reg;
        chars_next      = chars_reg;
        letters_next    = letters_reg;
        min_next        = min_reg;
        any_next        = any_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        shift           = 1'b0;
        col_inc         = 1'b0;
        match           = 1'b0;
        flag            = 1'b0;

        unique case (state_reg)
            lhlf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // A collect leaves the output register alone, since it may
                    // still hold a waiting result.
                    if (cmd.operation != lhlf_pkg::OP_COLLECT)
                    begin
                        out_next.status      = lhlf_pkg::STATUS_OK;
                        out_next.letter_code = '0;
                        out_next.hit_count   = '0;
                        out_next.total_count = 16'(chars_reg);
                        out_next.last        = 1'b1;
                    end
                    unique case (cmd.operation)
                        lhlf_pkg::OP_COLLECT:
                        begin
                            chars_next = lhlf_pkg::sat_inc(chars_reg);
                            if (info.is_letter)
                            begin
                                letters_next = lhlf_pkg::sat_inc(letters_reg);
                                col_inc      = 1'b1;
                            end
                        end
                        lhlf_pkg::OP_RATIO:
                        begin
                            out_valid_next = 1'b1;
                            if (chars_reg == '0)
                                out_next.status = lhlf_pkg::STATUS_EMPTY;
                            else
                                out_next.hit_count = 16'(letters_reg);
                        end
                        lhlf_pkg::OP_SINGLE:
                        begin
                            out_valid_next = 1'b1;
                            if (!info.is_letter)
                                out_next.status = lhlf_pkg::STATUS_NOT_LETTER;
                            else if (chars_reg == '0)
                                out_next.status = lhlf_pkg::STATUS_EMPTY;
                            else
                                out_next.hit_count = 16'(cell_q[info.idx].count);
                        end
                        lhlf_pkg::OP_REPORT:
                        begin
                            if (chars_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = lhlf_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = lhlf_pkg::ST_MINSCAN;
                                step_next  = '0;
                                any_next   = 1'b0;
                                min_next   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            lhlf_pkg::ST_MINSCAN:
            begin
                shift = 1'b1;
                if ((head.up || head.lo) && (!any_reg || head.count < min_reg))
                    min_next = head.count;
                any_next = any_reg || head.up || head.lo;
                if (step_reg == lhlf_pkg::LAST_LETTER)
                begin
                    step_next = '0;
                    if (!any_next)
                    begin
                        // The output register is empty here: nothing was loaded
                        // since the report was accepted.
                        out_valid_next       = 1'b1;
                        out_next.status      = lhlf_pkg::STATUS_NO_LETTERS;
                        out_next.letter_code = '0;
                        out_next.hit_count   = '0;
                        out_next.total_count = 16'(chars_reg);
                        out_next.last        = 1'b1;
                        state_next           = lhlf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lhlf_pkg::ST_EMIT_UP;
                    end
                end
                else
                begin
                    step_next = step_reg + lhlf_pkg::letter_idx_t'(1);
                end
            end

            lhlf_pkg::ST_EMIT_UP, lhlf_pkg::ST_EMIT_LO:
            begin
                flag  = (state_reg == lhlf_pkg::ST_EMIT_UP) ? head.up : head.lo;
                match = flag && (head.count == min_reg);
                // A match is held back until the next one, so the final one can carry last.
                if (!(match && pend_valid_reg && !out_free))
                begin
                    shift = 1'b1;
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next       = 1'b1;
                        pend_next.status      = lhlf_pkg::STATUS_OK;
                        pend_next.letter_code = ((state_reg == lhlf_pkg::ST_EMIT_UP) ?
                                                 lhlf_pkg::CHAR_UPPER_A :
                                                 lhlf_pkg::CHAR_LOWER_A) + 8'(step_reg);
                        pend_next.hit_count   = 16'(min_reg);
                        pend_next.total_count = 16'(chars_reg);
                        pend_next.last        = 1'b0;
                    end
                    if (step_reg == lhlf_pkg::LAST_LETTER)
                    begin
                        step_next  = '0;
                        state_next = (state_reg == lhlf_pkg::ST_EMIT_UP) ?
                                     lhlf_pkg::ST_EMIT_LO : lhlf_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        step_next = step_reg + lhlf_pkg::letter_idx_t'(1);
                    end
                end
            end

            lhlf_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = lhlf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lhlf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lhlf_pkg::ST_IDLE;
            step_reg       <= '0;
            chars_reg      <= '0;
            letters_reg    <= '0;
            any_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            chars_reg      <= chars_next;
            letters_reg    <= letters_next;
            any_reg        <= any_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg  <= min_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.letter_code = out_reg.letter_code;
    assign rsp.hit_count   = out_reg.hit_count;
    assign rsp.total_count = out_reg.total_count;
    assign rsp.last        = out_reg.last;

    // The ring is back in place and the step counter rewound whenever idle.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lhlf_pkg::ST_IDLE) |-> (step_reg == '0))
        else $error("step counter not rewound in idle");

    a_idle_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lhlf_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("held report result left behind");

    a_letters_le_chars: assert property (@(posedge clk) disable iff (!rst_n)
        letters_reg <= chars_reg)
        else $error("letter count above character count");

    a_minscan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lhlf_pkg::ST_MINSCAN) |-> !out_valid_reg)
        else $error("output register busy during minimum scan");

endmodule

`default_nettype wire

/* rtl/core/lhlf_cell.sv */
// One cell of the letter ring: a saturating counter and two case flags.
// Depends on lhlf_pkg.
`default_nettype none

module lhlf_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lhlf_pkg::cell_ctrl_t ctrl,
    input  wire lhlf_pkg::cell_data_t neighbor,
    output lhlf_pkg::cell_data_t     data
);

    lhlf_pkg::cell_data_t data_reg;
    lhlf_pkg::cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = neighbor;
        end
        else if (ctrl.inc)
        begin
            data_next.count = lhlf_pkg::sat_inc(data_reg.count);
            data_next.up    = data_reg.up | ctrl.mark_up;
            data_next.lo    = data_reg.lo | ctrl.mark_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* test/letter_histogram_least_frequent_tb.sv */
// Testbench of letter_histogram_least_frequent: random and directed commands with
// a scoreboard that predicts every result. Depends on lhlf_pkg, lhlf_if and the top of the RTL.
`timescale 1ns / 1ps

module letter_histogram_least_frequent_tb;

    import lhlf_pkg::*;

    class histogram_scoreboard;
        count_t  char_total;
        count_t  letter_total;
        count_t  fold_count[NUM_LETTERS];
        bit      code_present[2*NUM_LETTERS];
        result_t expected_results[$];
        int      mismatches;

        function new();
            char_total   = '0;
            letter_total = '0;
            mismatches   = 0;
            foreach (fold_count[i])
                fold_count[i] = '0;
            foreach (code_present[i])
                code_present[i] = 1'b0;
        endfunction

        // The index folds case; the slot keeps upper and lower case apart.
        function bit classify(input logic [7:0] ch, output int idx, output int slot);
            idx  = 0;
            slot = 0;
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
            begin
                idx  = ch - CHAR_UPPER_A;
                slot = idx;
                return 1'b1;
            end
            if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            begin
                idx  = ch - CHAR_LOWER_A;
                slot = NUM_LETTERS + idx;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push(status_t st, logic [7:0] code, count_t hit, count_t total,
                           logic last);
            result_t r;
            r.status      = st;
            r.letter_code = code;
            r.hit_count   = hit[15:0];
            r.total_count = total[15:0];
            r.last        = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_command(input logic [1:0] op, input logic [7:0] ch);
            int     idx;
            int     slot;
            int     tied;
            int     n;
            bit     is_letter;
            bit     any;
            count_t least;
            is_letter = classify(ch, idx, slot);
            case (op)
                OP_COLLECT:
                begin
                    if (char_total != COUNT_MAX)
                        char_total++;
                    if (is_letter)
                    begin
                        if (letter_total != COUNT_MAX)
                            letter_total++;
                        if (fold_count[idx] != COUNT_MAX)
                            fold_count[idx]++;
                        code_present[slot] = 1'b1;
                    end
                end
                OP_RATIO:
                begin
                    if (char_total == 0)
                        push(STATUS_EMPTY, 8'h00, '0, '0, 1'b1);
                    else
                        push(STATUS_OK, 8'h00, letter_total, char_total, 1'b1);
                end
                OP_SINGLE:
                begin
                    // A non-letter is flagged even when the store is empty.
                    if (!is_letter)
                        push(STATUS_NOT_LETTER, 8'h00, '0, char_total, 1'b1);
                    else if (char_total == 0)
                        push(STATUS_EMPTY, 8'h00, '0, '0, 1'b1);
                    else
                        push(STATUS_OK, 8'h00, fold_count[idx], char_total, 1'b1);
                end
                OP_REPORT:
                begin
                    if (char_total == 0)
                    begin
                        push(STATUS_EMPTY, 8'h00, '0, '0, 1'b1);
                        return;
                    end
                    any   = 1'b0;
                    least = '0;
                    for (int s = 0; s < 2*NUM_LETTERS; s++)
                    begin
                        if (code_present[s] &&
                            (!any || fold_count[s % NUM_LETTERS] < least))
                            least = fold_count[s % NUM_LETTERS];
                        if (code_present[s])
                            any = 1'b1;
                    end
                    if (!any)
                    begin
                        push(STATUS_NO_LETTERS, 8'h00, '0, char_total, 1'b1);
                        return;
                    end
                    tied = 0;
                    for (int s = 0; s < 2*NUM_LETTERS; s++)
                        if (code_present[s] && fold_count[s % NUM_LETTERS] == least)
                            tied++;
                    n = 0;
                    for (int s = 0; s < 2*NUM_LETTERS; s++)
                    begin
                        if (code_present[s] && fold_count[s % NUM_LETTERS] == least)
                        begin
                            n++;
                            push(STATUS_OK,
                                 (s < NUM_LETTERS) ? 8'(CHAR_UPPER_A + s)
                                                   : 8'(CHAR_LOWER_A + s - NUM_LETTERS),
                                 least, char_total, n == tied);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(input result_t got);
            result_t want;
            bit      bad;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result with none expected: ",
                              "st=%0d code=%0d hit=%0d tot=%0d last=%0d"},
                             $realtime, got.status, got.letter_code, got.hit_count,
                             got.total_count, got.last);
                return;
            end
            want = expected_results.pop_front();
            bad  = (got.status !== want.status) || (got.letter_code !== want.letter_code) ||
                   (got.hit_count !== want.hit_count) ||
                   (got.total_count !== want.total_count) || (got.last !== want.last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected st=%0d code=%0d hit=%0d tot=%0d last=%0d",
                             $realtime, want.status, want.letter_code, want.hit_count,
                             want.total_count, want.last);
                    $display("%0t: actual   st=%0d code=%0d hit=%0d tot=%0d last=%0d",
                             $realtime, got.status, got.letter_code, got.hit_count,
                             got.total_count, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    histogram_scoreboard sb = new();

    lhlf_cmd_if cmd_ch();
    lhlf_rsp_if rsp_ch();

    letter_histogram_least_frequent dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // valid stays high between back-to-back transactions and drops only for a gap.
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.character <= ch;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.note_command(op, ch);
    endtask

    function automatic logic [7:0] letter_byte(input int idx);
        return 8'(($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + idx);
    endfunction

    task automatic empty_store_checks();
        send_cmd(OP_RATIO, 8'h00);
        send_cmd(OP_SINGLE, 8'h40);
        send_cmd(OP_SINGLE, CHAR_LOWER_Z);
        send_cmd(OP_REPORT, 8'hFF);
        // Bytes at the ends of the byte range and right next to the letter ranges must count as characters only.
        send_cmd(OP_COLLECT, 8'h00);
        send_cmd(OP_COLLECT, 8'hFF);
        send_cmd(OP_COLLECT, 8'h40);
        send_cmd(OP_COLLECT, 8'h5B);
        send_cmd(OP_COLLECT, 8'h60);
        send_cmd(OP_COLLECT, 8'h7B);
        send_cmd(OP_REPORT, 8'h00);
        send_cmd(OP_RATIO, 8'hFF);
        send_cmd(OP_SINGLE, 8'h7B);
    endtask

    // Every letter code once, so the report ties all 52 codes.
    task automatic alphabet_sweep();
        logic [7:0] codes[2*NUM_LETTERS];
        logic [7:0] tmp;
        int         j;
        for (int i = 0; i < NUM_LETTERS; i++)
        begin
            codes[i]               = 8'(CHAR_UPPER_A + i);
            codes[NUM_LETTERS + i] = 8'(CHAR_LOWER_A + i);
        end
        for (int i = 2*NUM_LETTERS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = codes[i];
            codes[i] = codes[j];
            codes[j] = tmp;
        end
        foreach (codes[i])
            send_cmd(OP_COLLECT, codes[i]);
        send_cmd(OP_REPORT, 8'h00);
    endtask

    task automatic tie_checks();
        send_cmd(OP_COLLECT, CHAR_UPPER_A);
        send_cmd(OP_COLLECT, CHAR_LOWER_Z);
        send_cmd(OP_COLLECT, CHAR_LOWER_A);
        send_cmd(OP_COLLECT, CHAR_UPPER_Z);
        send_cmd(OP_REPORT, 8'h55);
        send_cmd(OP_SINGLE, CHAR_LOWER_A);
        send_cmd(OP_SINGLE, CHAR_UPPER_Z);
        send_cmd(OP_SINGLE, 8'(CHAR_UPPER_A + 12));
        send_cmd(OP_RATIO, 8'hAA);
    endtask

    task automatic random_item();
        int         pick;
        logic [1:0] op;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        if (pick < 70)
        begin
            op = OP_COLLECT;
            // A few hot letters keep counts close, so the minimum moves and ties occur.
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: ch = letter_byte($urandom_range(0, 5));
                5, 6, 7:       ch = letter_byte($urandom_range(0, NUM_LETTERS - 1));
                default:       ;
            endcase
        end
        else if (pick < 78)
            op = OP_RATIO;
        else if (pick < 90)
        begin
            op = OP_SINGLE;
            if ($urandom_range(0, 4) != 0)
                ch = letter_byte($urandom_range(0, NUM_LETTERS - 1));
        end
        else
            op = OP_REPORT;
        send_cmd(op, ch);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result('{status:      status_t'(rsp_ch.status),
                                  letter_code: rsp_ch.letter_code,
                                  hit_count:   rsp_ch.hit_count,
                                  total_count: rsp_ch.total_count,
                                  last:        rsp_ch.last});
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(2_000_000 * 12);
        $display("** letter_histogram_least_frequent: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_COLLECT;
        cmd_ch.character <= 8'h00;
        send_idle_pct  = 25;
        recv_stall_pct = 64;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        empty_store_checks();
        alphabet_sweep();
        tie_checks();
        repeat (110)
            random_item();

        send_idle_pct  = 64;
        recv_stall_pct = 25;
        repeat (110)
            random_item();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (105)
            random_item();

        cmd_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
        if (sb.mismatches == 0)
            $display("** letter_histogram_least_frequent: PASSED **");
        else
            $display("** letter_histogram_least_frequent: FAILED **");
        $finish;
    end

endmodule
